[rtl/core/i2cmrb_pkg.sv]
// Package for the I2C register burst master: phases, status codes, packing widths.
`timescale 1ns / 1ps
`default_nettype none
package i2cmrb_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_DLY, PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_A3, PH_WREQ, PH_R0, PH_R1, PH_R2,
        PH_K1, PH_K2, PH_K3, PH_P0, PH_P1, PH_P2, PH_P3, PH_P4
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0, CMD_WRITE = 2'd1, CMD_READ = 2'd2, CMD_RSVD = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NOSTRT = 2'd2;
    localparam logic [1:0] ST_NACK   = 2'd3;

    localparam logic [2:0] STG_ADDR  = 3'd0;
    localparam logic [2:0] STG_REG   = 3'd1;
    localparam logic [2:0] STG_WDATA = 3'd2;
    localparam logic [2:0] STG_RADDR = 3'd3;
    localparam logic [2:0] STG_RDATA = 3'd4;

    localparam logic [15:0] DELAY_RESET = 16'd50;

    // classified tick from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] dev;
        logic [7:0] regad;
        logic [7:0] len;
        logic [7:0] wdata;
        logic       wvalid;
        logic       sda;
    } t_tick;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rdata;
        logic       rvalid;
        logic       rlast;
        logic       dreq;
        logic       done;
        logic [1:0] status;
        logic       busy;
    } t_res;

    localparam int QDEPTH = 2;

endpackage
`default_nettype wire

[rtl/core/i2cmrb_front.sv]
// Input side: unpacks tick requests and queues them for the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module i2cmrb_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [39:0]          i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output i2cmrb_pkg::t_tick         o_tick
);
    i2cmrb_pkg::t_tick r_q [i2cmrb_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    i2cmrb_pkg::t_tick w_in;
    logic w_push, w_pop;

    always_comb begin
        w_in.cmd    = i_data[1:0];
        w_in.dev    = i_data[8:2];
        w_in.regad  = i_data[16:9];
        w_in.len    = i_data[24:17];
        w_in.wdata  = i_data[32:25];
        w_in.wvalid = i_data[33];
        w_in.sda    = i_data[34];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tick  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/core/i2cmrb_back.sv]
// Bus sequencer: runs one tick per queued request, result held in an output register.
`timescale 1ns / 1ps
`default_nettype none
module i2cmrb_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [15:0]          i_delay,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire i2cmrb_pkg::t_tick    i_tick,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output i2cmrb_pkg::t_res          o_res
);
    i2cmrb_pkg::t_phase r_ph, n_ph;
    logic [15:0] r_dc, n_dc, w_hold;
    logic [3:0]  r_bc, n_bc;
    logic [7:0]  r_sh, n_sh, r_left, n_left, r_reg, n_reg;
    logic [6:0]  r_ta, n_ta;
    logic        r_rd, n_rd, r_scl, n_scl, r_sda, n_sda;
    logic [2:0]  r_stg, n_stg;
    logic [1:0]  r_rc, n_rc;
    i2cmrb_pkg::t_res w_res;
    logic r_ov;
    logic w_step;
    logic [3:0] w_bcm, w_bcp;
    logic [7:0] w_shr;

    assign o_ready = !r_ov || i_ready;
    assign w_step  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign w_hold  = ((i_delay == 16'd0) ? 16'd1 : i_delay) - 16'd1;
    assign w_bcm   = r_bc - 4'd1;
    assign w_bcp   = r_bc + 4'd1;
    assign w_shr   = {r_sh[6:0], i_tick.sda};

    // next state
    always_comb begin
        n_ph = r_ph; n_dc = r_dc; n_bc = r_bc; n_sh = r_sh; n_left = r_left;
        n_reg = r_reg; n_ta = r_ta; n_rd = r_rd; n_scl = r_scl; n_sda = r_sda;
        n_stg = r_stg; n_rc = r_rc;
        w_res = '0;
        if (r_ph == i2cmrb_pkg::PH_IDLE) begin
            if (i_tick.cmd == i2cmrb_pkg::CMD_WRITE || i_tick.cmd == i2cmrb_pkg::CMD_READ) begin
                n_ta = i_tick.dev; n_reg = i_tick.regad; n_left = i_tick.len;
                n_rd = (i_tick.cmd == i2cmrb_pkg::CMD_READ);
                n_stg = i2cmrb_pkg::STG_ADDR; n_bc = 4'd0; n_rc = i2cmrb_pkg::ST_OK;
                n_sda = 1'b1; n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_S1;
            end
        end else if (r_dc != 16'd0) begin
            n_dc = r_dc - 16'd1;
        end else begin
            case (r_ph)
                i2cmrb_pkg::PH_S0: begin
                    n_sda = 1'b1; n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_S1;
                end
                i2cmrb_pkg::PH_S1: begin
                    if (r_stg != i2cmrb_pkg::STG_RADDR && !i_tick.sda) begin
                        w_res.done = 1'b1; w_res.status = i2cmrb_pkg::ST_BUSY;
                        n_ph = i2cmrb_pkg::PH_IDLE; n_dc = 16'd0;
                    end else begin
                        n_sda = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_S2;
                    end
                end
                i2cmrb_pkg::PH_S2: begin
                    if (r_stg != i2cmrb_pkg::STG_RADDR && i_tick.sda) begin
                        w_res.done = 1'b1; w_res.status = i2cmrb_pkg::ST_NOSTRT;
                        n_ph = i2cmrb_pkg::PH_IDLE; n_dc = 16'd0;
                    end else begin
                        n_sda = 1'b0; n_dc = w_hold;
                        if (r_rd) begin
                            n_bc = 4'd3; n_ph = i2cmrb_pkg::PH_DLY;
                        end else begin
                            n_sh = {r_ta, 1'b0}; n_bc = 4'd0; n_ph = i2cmrb_pkg::PH_B0;
                        end
                    end
                end
                i2cmrb_pkg::PH_DLY: begin
                    n_dc = w_hold; n_bc = w_bcm;
                    if (w_bcm == 4'd0) begin
                        if (r_stg == i2cmrb_pkg::STG_REG) begin
                            n_stg = i2cmrb_pkg::STG_RADDR; n_ph = i2cmrb_pkg::PH_S0;
                        end else begin
                            // load: write address, else read address
                            if (r_stg == i2cmrb_pkg::STG_ADDR) n_sh = {r_ta, 1'b0};
                            else n_sh = {r_ta, 1'b1};
                            n_bc = 4'd0; n_ph = i2cmrb_pkg::PH_B0;
                        end
                    end
                end
                i2cmrb_pkg::PH_B0: begin
                    n_scl = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_B1;
                end
                i2cmrb_pkg::PH_B1: begin
                    n_sda = r_sh[7]; n_sh = {r_sh[6:0], 1'b0}; n_dc = w_hold;
                    n_ph = i2cmrb_pkg::PH_B2;
                end
                i2cmrb_pkg::PH_B2: begin
                    n_scl = 1'b1; n_dc = w_hold;
                    if (w_bcp >= 4'd8) begin
                        n_bc = 4'd0; n_ph = i2cmrb_pkg::PH_A0;
                    end else begin
                        n_bc = w_bcp; n_ph = i2cmrb_pkg::PH_B0;
                    end
                end
                i2cmrb_pkg::PH_A0: begin
                    n_scl = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_A1;
                end
                i2cmrb_pkg::PH_A1: begin
                    n_sda = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_A2;
                end
                i2cmrb_pkg::PH_A2: begin
                    n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_A3;
                end
                i2cmrb_pkg::PH_A3: begin
                    n_scl = 1'b0; n_dc = w_hold;
                    if (r_stg != i2cmrb_pkg::STG_RADDR && i_tick.sda) begin
                        n_rc = i2cmrb_pkg::ST_NACK; n_ph = i2cmrb_pkg::PH_P1;
                    end else if (r_stg == i2cmrb_pkg::STG_ADDR) begin
                        n_stg = i2cmrb_pkg::STG_REG; n_sh = r_reg; n_bc = 4'd0;
                        n_ph = i2cmrb_pkg::PH_B1;
                    end else if (r_stg == i2cmrb_pkg::STG_REG) begin
                        if (r_rd) begin
                            n_bc = 4'd2; n_ph = i2cmrb_pkg::PH_DLY;
                        end else if (r_left == 8'd0) begin
                            n_ph = i2cmrb_pkg::PH_P1;
                        end else begin
                            n_stg = i2cmrb_pkg::STG_WDATA; n_ph = i2cmrb_pkg::PH_WREQ;
                        end
                    end else if (r_stg == i2cmrb_pkg::STG_WDATA) begin
                        n_left = r_left - 8'd1;
                        n_ph = (r_left != 8'd1) ? i2cmrb_pkg::PH_WREQ : i2cmrb_pkg::PH_P1;
                    end else begin
                        if (r_left == 8'd0) begin
                            n_ph = i2cmrb_pkg::PH_P1;
                        end else begin
                            n_stg = i2cmrb_pkg::STG_RDATA; n_sda = 1'b1; n_bc = 4'd0;
                            n_sh = 8'd0; n_ph = i2cmrb_pkg::PH_R1;
                        end
                    end
                end
                i2cmrb_pkg::PH_WREQ: begin
                    if (i_tick.wvalid) begin
                        n_sda = i_tick.wdata[7]; n_sh = {i_tick.wdata[6:0], 1'b0};
                        n_bc = 4'd0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_B2;
                    end
                end
                i2cmrb_pkg::PH_R0: begin
                    n_sda = 1'b1; n_scl = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_R1;
                end
                i2cmrb_pkg::PH_R1: begin
                    n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_R2;
                end
                i2cmrb_pkg::PH_R2: begin
                    n_sh = w_shr; n_scl = 1'b0; n_dc = w_hold;
                    if (w_bcp < 4'd8) begin
                        n_bc = w_bcp; n_ph = i2cmrb_pkg::PH_R1;
                    end else begin
                        w_res.rvalid = 1'b1; w_res.rdata = w_shr;
                        w_res.rlast = (r_left == 8'd1);
                        n_bc = 4'd0; n_ph = i2cmrb_pkg::PH_K1;
                    end
                end
                i2cmrb_pkg::PH_K1: begin
                    n_sda = (r_left == 8'd1); n_dc = w_hold; n_ph = i2cmrb_pkg::PH_K2;
                end
                i2cmrb_pkg::PH_K2: begin
                    n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_K3;
                end
                i2cmrb_pkg::PH_K3: begin
                    n_scl = 1'b0; n_dc = w_hold; n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_ph = i2cmrb_pkg::PH_P0;
                    end else begin
                        n_sh = 8'd0; n_ph = i2cmrb_pkg::PH_R0;
                    end
                end
                i2cmrb_pkg::PH_P0: begin
                    n_scl = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_P1;
                end
                i2cmrb_pkg::PH_P1: begin
                    n_sda = 1'b0; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_P2;
                end
                i2cmrb_pkg::PH_P2: begin
                    n_scl = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_P3;
                end
                i2cmrb_pkg::PH_P3: begin
                    n_sda = 1'b1; n_dc = w_hold; n_ph = i2cmrb_pkg::PH_P4;
                end
                i2cmrb_pkg::PH_P4: begin
                    w_res.done = 1'b1; w_res.status = r_rc;
                    n_ph = i2cmrb_pkg::PH_IDLE; n_dc = 16'd0;
                end
                default: begin
                    w_res.done = 1'b1; w_res.status = i2cmrb_pkg::ST_OK;
                    n_ph = i2cmrb_pkg::PH_IDLE; n_dc = 16'd0;
                end
            endcase
        end
        w_res.scl  = n_scl;
        w_res.sda  = n_sda;
        w_res.dreq = (n_ph == i2cmrb_pkg::PH_WREQ) && (n_dc == 16'd0);
        w_res.busy = (n_ph != i2cmrb_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= i2cmrb_pkg::PH_IDLE; r_dc <= 16'd0; r_bc <= 4'd0; r_sh <= 8'd0;
            r_left <= 8'd0; r_ta <= 7'd0; r_reg <= 8'd0; r_rd <= 1'b0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_stg <= i2cmrb_pkg::STG_ADDR;
            r_rc <= i2cmrb_pkg::ST_OK; r_ov <= 1'b0;
        end else begin
            if (w_step) begin
                r_ph <= n_ph; r_dc <= n_dc; r_bc <= n_bc; r_sh <= n_sh;
                r_left <= n_left; r_ta <= n_ta; r_reg <= n_reg; r_rd <= n_rd;
                r_scl <= n_scl; r_sda <= n_sda; r_stg <= n_stg; r_rc <= n_rc;
            end
            if (o_ready) r_ov <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) o_res <= w_res;
    end
endmodule
`default_nettype wire

[rtl/core/i2c_master_register_burst.sv]
// Top level of the I2C register burst master.
`timescale 1ns / 1ps
`default_nettype none
// Each input request is one bus tick; the sequencer takes one per clock and returns
// exactly one result per request, registered as it leaves the two-entry input queue.
// Sustained rate is one request per clock, limited by the single-cycle phase sequencer;
// a stalled master side backs up the queue and then deasserts s_axis_tready.
// delay_ticks (reset 50): write via cfg_valid/cfg_ready only while idle; not enforced.
module i2c_master_register_burst (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0] device_address[8:2] register_address[16:9] burst_length[24:17]
    // write_data[32:25] write_valid[33] sda_in[34]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // scl_out[0] sda_out[1] read_data[9:2] read_valid[10] read_last[11]
    // data_request[12] done_res[13] status[15:14] busy_res[16]
    output logic [23:0]      m_axis_tdata
);
    logic [15:0] r_delay;
    logic w_qv, w_qr;
    i2cmrb_pkg::t_tick w_tick;
    i2cmrb_pkg::t_res  w_res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_delay <= i2cmrb_pkg::DELAY_RESET;
        else if (cfg_valid) r_delay <= cfg_data;
    end

    i2cmrb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(w_qv), .i_ready(w_qr), .o_tick(w_tick)
    );

    i2cmrb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_delay(r_delay),
        .i_valid(w_qv), .o_ready(w_qr), .i_tick(w_tick),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.busy, w_res.status, w_res.done, w_res.dreq,
                           w_res.rlast, w_res.rvalid, w_res.rdata, w_res.sda, w_res.scl};
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the I2C register burst master.
`timescale 1ns / 1ps
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    i2c_master_register_burst i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // bus engine copy
    logic [15:0]          m_delay;
    i2cmrb_pkg::t_phase   m_phase;
    logic [15:0]          m_dcnt;
    logic [3:0]           m_bits;
    logic [7:0]           m_shift, m_left;
    logic [6:0]           m_dev;
    logic [7:0]           m_reg;
    logic                 m_rd, m_scl, m_sda;
    logic [2:0]           m_stage;
    logic [1:0]           m_code;
    i2cmrb_pkg::t_res     tick_out;

    i2cmrb_pkg::t_res     expected_q[$];
    int          errors = 0;
    int          ticks_sent = 0;
    int          bursts_done = 0;
    int          bytes_read = 0;
    int          idle_cycles = 0;
    bit          rx_hold = 0;
    bit          no_gaps = 0;

    function automatic logic [15:0] step_len();
        return (m_delay == 16'd0) ? 16'd0 : m_delay - 16'd1;
    endfunction

    task automatic end_burst(input logic [1:0] code);
        tick_out.done   = 1'b1;
        tick_out.status = code;
        m_phase = i2cmrb_pkg::PH_IDLE;
        m_dcnt  = '0;
    endtask

    task automatic next_byte();
        if (m_stage == i2cmrb_pkg::STG_ADDR) m_shift = {m_dev, 1'b0};
        else if (m_stage == i2cmrb_pkg::STG_REG) m_shift = m_reg;
        else m_shift = {m_dev, 1'b1};
        m_bits = '0;
    endtask

    task automatic drive_bit();
        m_sda   = m_shift[7];
        m_shift = m_shift << 1;
        m_dcnt  = step_len();
        m_phase = i2cmrb_pkg::PH_B2;
    endtask

    task automatic engine_reset();
        m_delay = i2cmrb_pkg::DELAY_RESET;
        m_phase = i2cmrb_pkg::PH_IDLE; m_dcnt = '0; m_bits = '0; m_shift = '0; m_left = '0;
        m_dev = '0; m_reg = '0; m_rd = 1'b0; m_scl = 1'b1; m_sda = 1'b1;
        m_stage = i2cmrb_pkg::STG_ADDR; m_code = i2cmrb_pkg::ST_OK;
    endtask

    task automatic predict_tick(input i2cmrb_pkg::t_tick t);
        tick_out = '0;
        if (m_phase == i2cmrb_pkg::PH_IDLE) begin
            if (t.cmd == i2cmrb_pkg::CMD_WRITE || t.cmd == i2cmrb_pkg::CMD_READ) begin
                m_dev = t.dev; m_reg = t.regad; m_left = t.len;
                m_rd = (t.cmd == i2cmrb_pkg::CMD_READ);
                m_stage = i2cmrb_pkg::STG_ADDR; m_bits = '0; m_code = i2cmrb_pkg::ST_OK;
                m_sda = 1'b1; m_scl = 1'b1; m_dcnt = step_len();
                m_phase = i2cmrb_pkg::PH_S1;
            end
        end else if (m_dcnt != 16'd0) begin
            m_dcnt = m_dcnt - 16'd1;
        end else begin
            case (m_phase)
                i2cmrb_pkg::PH_S0: begin
                    m_sda = 1'b1; m_scl = 1'b1; m_dcnt = step_len();
                    m_phase = i2cmrb_pkg::PH_S1;
                end
                i2cmrb_pkg::PH_S1: begin
                    if (m_stage != i2cmrb_pkg::STG_RADDR && !t.sda)
                        end_burst(i2cmrb_pkg::ST_BUSY);
                    else begin
                        m_sda = 1'b0; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_S2;
                    end
                end
                i2cmrb_pkg::PH_S2: begin
                    if (m_stage != i2cmrb_pkg::STG_RADDR && t.sda)
                        end_burst(i2cmrb_pkg::ST_NOSTRT);
                    else begin
                        m_sda = 1'b0; m_dcnt = step_len();
                        if (m_rd) begin
                            m_bits = 4'd3; m_phase = i2cmrb_pkg::PH_DLY;
                        end else begin
                            next_byte(); m_phase = i2cmrb_pkg::PH_B0;
                        end
                    end
                end
                i2cmrb_pkg::PH_DLY: begin
                    m_dcnt = step_len();
                    m_bits = m_bits - 4'd1;
                    if (m_bits == 4'd0) begin
                        if (m_stage == i2cmrb_pkg::STG_REG) begin
                            m_stage = i2cmrb_pkg::STG_RADDR; m_phase = i2cmrb_pkg::PH_S0;
                        end else begin
                            next_byte(); m_phase = i2cmrb_pkg::PH_B0;
                        end
                    end
                end
                i2cmrb_pkg::PH_B0: begin
                    m_scl = 1'b0; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_B1;
                end
                i2cmrb_pkg::PH_B1: drive_bit();
                i2cmrb_pkg::PH_B2: begin
                    m_scl = 1'b1; m_dcnt = step_len();
                    m_bits = m_bits + 4'd1;
                    if (m_bits >= 4'd8) begin
                        m_bits = 4'd0; m_phase = i2cmrb_pkg::PH_A0;
                    end else m_phase = i2cmrb_pkg::PH_B0;
                end
                i2cmrb_pkg::PH_A0: begin
                    m_scl = 1'b0; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_A1;
                end
                i2cmrb_pkg::PH_A1: begin
                    m_sda = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_A2;
                end
                i2cmrb_pkg::PH_A2: begin
                    m_scl = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_A3;
                end
                i2cmrb_pkg::PH_A3: begin
                    m_scl = 1'b0; m_dcnt = step_len();
                    if (m_stage != i2cmrb_pkg::STG_RADDR && t.sda) begin
                        m_code = i2cmrb_pkg::ST_NACK; m_phase = i2cmrb_pkg::PH_P1;
                    end else if (m_stage == i2cmrb_pkg::STG_ADDR) begin
                        m_stage = i2cmrb_pkg::STG_REG; next_byte();
                        m_phase = i2cmrb_pkg::PH_B1;
                    end else if (m_stage == i2cmrb_pkg::STG_REG) begin
                        if (m_rd) begin
                            m_bits = 4'd2; m_phase = i2cmrb_pkg::PH_DLY;
                        end else if (m_left == 8'd0) m_phase = i2cmrb_pkg::PH_P1;
                        else begin
                            m_stage = i2cmrb_pkg::STG_WDATA; m_phase = i2cmrb_pkg::PH_WREQ;
                        end
                    end else if (m_stage == i2cmrb_pkg::STG_WDATA) begin
                        m_left = m_left - 8'd1;
                        m_phase = (m_left != 8'd0) ? i2cmrb_pkg::PH_WREQ : i2cmrb_pkg::PH_P1;
                    end else begin
                        if (m_left == 8'd0) m_phase = i2cmrb_pkg::PH_P1;
                        else begin
                            m_stage = i2cmrb_pkg::STG_RDATA; m_sda = 1'b1; m_bits = 4'd0;
                            m_shift = 8'd0; m_phase = i2cmrb_pkg::PH_R1;
                        end
                    end
                end
                i2cmrb_pkg::PH_WREQ: begin
                    if (t.wvalid) begin
                        m_shift = t.wdata; m_bits = 4'd0; drive_bit();
                    end
                end
                i2cmrb_pkg::PH_R0: begin
                    m_sda = 1'b1; m_scl = 1'b0; m_dcnt = step_len();
                    m_phase = i2cmrb_pkg::PH_R1;
                end
                i2cmrb_pkg::PH_R1: begin
                    m_scl = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_R2;
                end
                i2cmrb_pkg::PH_R2: begin
                    m_shift = {m_shift[6:0], t.sda};
                    m_bits = m_bits + 4'd1;
                    m_scl = 1'b0; m_dcnt = step_len();
                    if (m_bits < 4'd8) m_phase = i2cmrb_pkg::PH_R1;
                    else begin
                        tick_out.rvalid = 1'b1; tick_out.rdata = m_shift;
                        tick_out.rlast = (m_left == 8'd1);
                        m_bits = 4'd0; m_phase = i2cmrb_pkg::PH_K1;
                    end
                end
                i2cmrb_pkg::PH_K1: begin
                    m_sda = (m_left == 8'd1); m_dcnt = step_len();
                    m_phase = i2cmrb_pkg::PH_K2;
                end
                i2cmrb_pkg::PH_K2: begin
                    m_scl = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_K3;
                end
                i2cmrb_pkg::PH_K3: begin
                    m_scl = 1'b0; m_dcnt = step_len();
                    m_left = m_left - 8'd1;
                    if (m_left == 8'd0) m_phase = i2cmrb_pkg::PH_P0;
                    else begin
                        m_shift = 8'd0; m_phase = i2cmrb_pkg::PH_R0;
                    end
                end
                i2cmrb_pkg::PH_P0: begin
                    m_scl = 1'b0; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_P1;
                end
                i2cmrb_pkg::PH_P1: begin
                    m_sda = 1'b0; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_P2;
                end
                i2cmrb_pkg::PH_P2: begin
                    m_scl = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_P3;
                end
                i2cmrb_pkg::PH_P3: begin
                    m_sda = 1'b1; m_dcnt = step_len(); m_phase = i2cmrb_pkg::PH_P4;
                end
                i2cmrb_pkg::PH_P4: end_burst(m_code);
                default: end_burst(i2cmrb_pkg::ST_OK);
            endcase
        end
        tick_out.scl  = m_scl;
        tick_out.sda  = m_sda;
        tick_out.dreq = (m_phase == i2cmrb_pkg::PH_WREQ && m_dcnt == 16'd0);
        tick_out.busy = (m_phase != i2cmrb_pkg::PH_IDLE);
        expected_q.push_back(tick_out);
    endtask

    function automatic logic [39:0] pack_tick(input i2cmrb_pkg::t_tick t);
        return {5'd0, t.sda, t.wvalid, t.wdata, t.len, t.regad, t.dev, t.cmd};
    endfunction

    task automatic send_tick(input i2cmrb_pkg::t_tick t);
        if (!no_gaps && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 7) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_tick(t);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_tick(t);
        ticks_sent++;
    endtask

    // Bus side: ack unless nack_pct hits; busy/nostart chance at start checks.
    int nack_pct = 0;
    int glitch_pct = 0;

    function automatic logic pick_sda();
        case (m_phase)
            i2cmrb_pkg::PH_S1: return ($urandom_range(99) < glitch_pct) ? 1'b0 : 1'b1;
            i2cmrb_pkg::PH_S2: return ($urandom_range(99) < glitch_pct) ? 1'b1 : 1'b0;
            i2cmrb_pkg::PH_A3: return ($urandom_range(99) < nack_pct) ? 1'b1 : 1'b0;
            default: return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic run_burst(input i2cmrb_pkg::t_cmd cmd, input logic [6:0] dev,
                             input logic [7:0] regad, input logic [7:0] len);
        i2cmrb_pkg::t_tick t;
        t = '0;
        t.cmd = cmd; t.dev = dev; t.regad = regad; t.len = len; t.sda = 1'b1;
        t.wdata = 8'($urandom); t.wvalid = 1'($urandom);
        send_tick(t);
        while (m_phase != i2cmrb_pkg::PH_IDLE) begin
            t = '0;
            t.cmd    = i2cmrb_pkg::t_cmd'($urandom_range(3));
            t.dev    = 7'($urandom);
            t.regad  = 8'($urandom);
            t.len    = 8'($urandom);
            t.wdata  = 8'($urandom);
            t.wvalid = ($urandom_range(3) != 0);
            t.sda    = pick_sda();
            send_tick(t);
        end
        if (cmd == i2cmrb_pkg::CMD_WRITE || cmd == i2cmrb_pkg::CMD_READ) bursts_done++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        m_delay = value;
    endtask

    task automatic test_directed();
        i2cmrb_pkg::t_tick t;
        write_delay(16'd1);
        t = '0; t.cmd = i2cmrb_pkg::CMD_RSVD; t.sda = 1'b1; send_tick(t);
        t = '0; t.cmd = i2cmrb_pkg::CMD_NONE; t.dev = '1; t.regad = '1; t.len = '1;
        t.wdata = '1; t.wvalid = 1'b1; send_tick(t);
        glitch_pct = 100; run_burst(i2cmrb_pkg::CMD_WRITE, 7'h7f, 8'hff, 8'd1);
        glitch_pct = 0;
        // bus busy: sda low on release
        t = '0; t.cmd = i2cmrb_pkg::CMD_WRITE; t.sda = 1'b1; send_tick(t);
        t = '0; t.sda = 1'b0; send_tick(t);
        // start not seen
        t = '0; t.cmd = i2cmrb_pkg::CMD_READ; t.sda = 1'b1; send_tick(t);
        t = '0; t.sda = 1'b1; send_tick(t);
        t = '0; t.sda = 1'b1; send_tick(t);
        run_burst(i2cmrb_pkg::CMD_WRITE, 7'h00, 8'h00, 8'd0);
        run_burst(i2cmrb_pkg::CMD_READ, 7'h55, 8'h80, 8'd0);
        nack_pct = 100; run_burst(i2cmrb_pkg::CMD_WRITE, 7'h2a, 8'h11, 8'd3);
        nack_pct = 0;
        write_delay(16'd0);
        run_burst(i2cmrb_pkg::CMD_READ, 7'h7f, 8'hff, 8'd2);
    endtask

    task automatic test_random(input int tick_budget);
        int stop_at;
        i2cmrb_pkg::t_cmd cmd;
        stop_at = ticks_sent + tick_budget;
        while (ticks_sent < stop_at) begin
            nack_pct   = ($urandom_range(9) == 0) ? 30 : 2;
            glitch_pct = ($urandom_range(9) == 0) ? 40 : 0;
            cmd = ($urandom_range(1) != 0) ? i2cmrb_pkg::CMD_READ : i2cmrb_pkg::CMD_WRITE;
            run_burst(cmd, 7'($urandom), 8'($urandom),
                      ($urandom_range(9) == 0) ? 8'($urandom_range(12, 4)) :
                                                 8'($urandom_range(3)));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (40) @(posedge i_clk);
                rx_hold = 0;
            end
            run_burst(i2cmrb_pkg::CMD_WRITE, 7'h31, 8'h42, 8'd1);
        join
    endtask

    task automatic test_delays();
        write_delay(16'd2);
        test_random(200);
        no_gaps = 1;
        write_delay(16'd1);
        test_random(100);
        no_gaps = 0;
        test_backpressure();
        write_delay(16'hffff);
        // longest step setting with the bus idle: no burst is started
        begin
            i2cmrb_pkg::t_tick t;
            repeat (4) begin
                t = '0;
                t.cmd = ($urandom_range(1) != 0) ? i2cmrb_pkg::CMD_RSVD : i2cmrb_pkg::CMD_NONE;
                t.sda = 1'($urandom);
                send_tick(t);
            end
        end
        write_delay(16'd1);
        test_random(200);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !rx_hold && (no_gaps || $urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        i2cmrb_pkg::t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.scl    = m_axis_tdata[0];
            got.sda    = m_axis_tdata[1];
            got.rdata  = m_axis_tdata[9:2];
            got.rvalid = m_axis_tdata[10];
            got.rlast  = m_axis_tdata[11];
            got.dreq   = m_axis_tdata[12];
            got.done   = m_axis_tdata[13];
            got.status = m_axis_tdata[15:14];
            got.busy   = m_axis_tdata[16];
            if (got.rvalid) bytes_read++;
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.scl !== want.scl) begin
                    $error("scl_out exp %0d got %0d", want.scl, got.scl); errors++;
                end
                if (got.sda !== want.sda) begin
                    $error("sda_out exp %0d got %0d", want.sda, got.sda); errors++;
                end
                if (got.rdata !== want.rdata) begin
                    $error("read_data exp %h got %h", want.rdata, got.rdata); errors++;
                end
                if (got.rvalid !== want.rvalid) begin
                    $error("read_valid exp %0d got %0d", want.rvalid, got.rvalid); errors++;
                end
                if (got.rlast !== want.rlast) begin
                    $error("read_last exp %0d got %0d", want.rlast, got.rlast); errors++;
                end
                if (got.dreq !== want.dreq) begin
                    $error("data_request exp %0d got %0d", want.dreq, got.dreq); errors++;
                end
                if (got.done !== want.done) begin
                    $error("done_res exp %0d got %0d", want.done, got.done); errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res exp %0d got %0d", want.busy, got.busy); errors++;
                end
            end
        end
    end

    // watchdog: any accepted handshake resets the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        engine_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_delays();
        wait_drained();
        $display("covered %0d ticks, %0d bursts, %0d bytes read",
                 ticks_sent, bursts_done, bytes_read);
        $display("delay steps 0, 1, 2 and 65535 (idle); nack, busy and no-start aborts");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[i2c_master_register_burst.f]
rtl/core/i2cmrb_pkg.sv
rtl/core/i2cmrb_front.sv
rtl/core/i2cmrb_back.sv
rtl/core/i2c_master_register_burst.sv
bench/tb_top.sv
